FILE: hdl/triangular_band_matvec_top_assert.svh
// assertion macros used by the checker file
`ifndef TRIANGULAR_BAND_MATVEC_TOP_ASSERT_SVH
`define TRIANGULAR_BAND_MATVEC_TOP_ASSERT_SVH

// condition that holds at every edge out of reset
`define TBMV_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies the consequent in the same cycle
`define TBMV_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies the consequent in the next cycle
`define TBMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tbmv_pkg.sv
package tbmv_pkg;

  localparam int OP_W    = 2;
  localparam int ROW_W   = 10;
  localparam int BROW_W  = 5;
  localparam int DATA_W  = 16;
  localparam int SUM_W   = 40;
  localparam int PROD_W  = 33;
  localparam int N_W     = 17;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 11;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [CIDX_W-1:0] cfg_idx_t;

  localparam op_t OP_BAND_WRITE = 2'd0;
  localparam op_t OP_VEC_WRITE  = 2'd1;
  localparam op_t OP_COMPUTE    = 2'd2;

  localparam cfg_idx_t CFG_UPPER_BAND     = 3'd0;
  localparam cfg_idx_t CFG_UNIT_DIAGONAL  = 3'd1;
  localparam cfg_idx_t CFG_TRANSPOSE_MODE = 3'd2;
  localparam cfg_idx_t CFG_VECTOR_LENGTH  = 3'd3;
  localparam cfg_idx_t CFG_BAND_WIDTH     = 3'd4;

  localparam logic [CDATA_W-1:0] VECTOR_LENGTH_RESET = 11'd1024;

endpackage

FILE: hdl/tbmv_if.sv
interface tbmv_cfg_if import tbmv_pkg::*; ();
  logic                valid;
  logic                ready;
  cfg_idx_t            index;
  logic [CDATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface tbmv_req_if import tbmv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  op_t                       op;
  logic [ROW_W-1:0]          index;
  logic [BROW_W-1:0]         band_row;
  logic signed [DATA_W-1:0]  value;

  modport source (output valid, op, index, band_row, value, input ready);
  modport sink   (input valid, op, index, band_row, value, output ready);
endinterface

interface tbmv_rsp_if import tbmv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         row_index;
  logic signed [SUM_W-1:0]  sum;
  logic                     index_error;

  modport source (output valid, row_index, sum, index_error, input ready);
  modport sink   (input valid, row_index, sum, index_error, output ready);
endinterface

FILE: hdl/triangular_band_matvec_top.sv
// band and vector writes: one transaction per cycle while no compute row is in progress, no result
// compute row with t band terms: terms are read, multiplied and accumulated in turn and
//   the sum goes to the output register before the next item is taken; t = min(k, terms left) + 1, at most 32
// compute time is set by one read of the band store per term through one multiplier
// row beyond the order: no terms are read; the result carries a zero sum and index_error set
// reset restores the configuration defaults; band and vector stores are not cleared
module triangular_band_matvec_top import tbmv_pkg::*; #(
  parameter int MAX_SIZE      = 1024,
  parameter int MAX_BAND_ROWS = 32
) (
  input logic        clk,
  input logic        rst,
  tbmv_cfg_if.sink   cfg,
  tbmv_req_if.sink   req,
  tbmv_rsp_if.source rsp
);

  localparam int VA_W       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int BAND_DEPTH = MAX_SIZE * MAX_BAND_ROWS;
  localparam int BA_W       = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
  localparam logic [N_W-1:0] MAX_N     = N_W'(MAX_SIZE);
  localparam logic [8:0]     BAND_ROWS = 9'(MAX_BAND_ROWS);

  // control states
  localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a transaction
  localparam logic [1:0] ST_RUN   = 2'd1;  // issuing one band term per cycle
  localparam logic [1:0] ST_DRAIN = 2'd2;  // read and multiply stages emptying
  localparam logic [1:0] ST_FIN   = 2'd3;  // sum complete, waiting for output slot

  // configuration registers
  logic               upper_band;
  logic               unit_diagonal;
  logic [1:0]         transpose_mode;
  logic [CDATA_W-1:0] vector_length;
  logic [BROW_W-1:0]  band_width;

  // storage: band store addressed column * band rows + band row
  logic signed [DATA_W-1:0] band_mem [BAND_DEPTH];
  logic signed [DATA_W-1:0] vec_mem  [MAX_SIZE];
  logic signed [DATA_W-1:0] band_q;
  logic signed [DATA_W-1:0] vec_q;

  logic [1:0]          state;
  logic [N_W-1:0]      row;
  logic                row_err;
  logic [BROW_W:0]     d;
  logic                s1_valid;
  logic                s1_unit;
  logic                s1_zero;
  logic                s2_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;

  // output register
  logic                     rsp_valid;
  logic [ROW_W-1:0]         rsp_row;
  logic signed [SUM_W-1:0]  rsp_sum;
  logic                     rsp_err;

  logic [N_W-1:0]    n_eff;
  logic              forward;
  logic              transposed;
  logic              req_fire;
  logic [N_W-1:0]    req_idx;
  logic [N_W-1:0]    j;
  logic [N_W-1:0]    d_ext;
  logic [N_W-1:0]    col;
  logic [BROW_W-1:0] brow;
  logic              term_ok;
  logic              issue;
  logic              out_free;
  logic              band_we;
  logic              vec_we;
  logic [BA_W-1:0]   band_waddr;
  logic [BA_W-1:0]   band_raddr;
  logic [VA_W-1:0]   vec_waddr;
  logic [VA_W-1:0]   vec_raddr;
  logic signed [DATA_W:0] a_sel;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  assign rsp.valid       = rsp_valid;
  assign rsp.row_index   = rsp_row;
  assign rsp.sum         = rsp_sum;
  assign rsp.index_error = rsp_err;

  // order limited to the store size
  assign n_eff      = (N_W'(vector_length) > MAX_N) ? MAX_N : N_W'(vector_length);
  assign transposed = (transpose_mode != 2'd0);
  // partner index runs up for upper plain and lower transposed
  assign forward    = (upper_band != transposed);
  assign req_idx    = N_W'(req.index);

  // term address generation
  assign d_ext   = N_W'(d);
  assign j       = forward ? (row + d_ext) : (row - d_ext);
  assign col     = transposed ? row : j;
  assign brow    = upper_band ? (band_width - d[BROW_W-1:0]) : d[BROW_W-1:0];
  assign term_ok = (d <= {1'b0, band_width}) && (forward ? (j < n_eff) : (d_ext <= row));
  assign issue   = (state == ST_RUN) && term_ok;
  assign out_free = !rsp_valid || rsp.ready;

  assign band_raddr = BA_W'(32'(col) * 32'(MAX_BAND_ROWS) + 32'(brow));
  assign vec_raddr  = VA_W'(j);

  // write decode, entries beyond the store are dropped
  assign band_we    = req_fire && (req.op == OP_BAND_WRITE)
                      && (9'(req.band_row) < BAND_ROWS) && (req_idx < MAX_N);
  assign vec_we     = req_fire && (req.op == OP_VEC_WRITE) && (req_idx < MAX_N);
  assign band_waddr = BA_W'(32'(req.index) * 32'(MAX_BAND_ROWS) + 32'(req.band_row));
  assign vec_waddr  = VA_W'(req.index);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_band     <= 1'b1;
      unit_diagonal  <= 1'b0;
      transpose_mode <= 2'd0;
      vector_length  <= VECTOR_LENGTH_RESET;
      band_width     <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_UPPER_BAND:     upper_band     <= cfg.data[0];
        CFG_UNIT_DIAGONAL:  unit_diagonal  <= cfg.data[0];
        CFG_TRANSPOSE_MODE: transpose_mode <= cfg.data[1:0];
        CFG_VECTOR_LENGTH:  vector_length  <= cfg.data;
        CFG_BAND_WIDTH:     band_width     <= cfg.data[BROW_W-1:0];
        default: ;
      endcase
    end
  end

  // band store, registered read port
  always_ff @(posedge clk) begin
    if (band_we) begin
      band_mem[band_waddr] <= req.value;
    end
    if (issue) begin
      band_q <= band_mem[band_raddr];
    end
  end

  // vector store, registered read port
  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= req.value;
    end
    if (issue) begin
      vec_q <= vec_mem[vec_raddr];
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_fire && (req.op == OP_COMPUTE)) begin
            state <= (req_idx >= n_eff) ? ST_FIN : ST_RUN;
          end
        end
        ST_RUN: begin
          if (!term_ok) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // row capture and term counter
  always_ff @(posedge clk) begin
    if (req_fire && (req.op == OP_COMPUTE)) begin
      row     <= req_idx;
      row_err <= (req_idx >= n_eff);
      d       <= '0;
    end else if (issue) begin
      d <= d + 1'b1;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // term side info travels with the read
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_unit <= (d == '0) && unit_diagonal;
      s1_zero <= (9'(brow) >= BAND_ROWS);
    end
  end

  // unit diagonal multiplies by one in Q1.15, band rows beyond the store read zero
  always_comb begin
    if (s1_unit) begin
      a_sel = 17'sh08000;
    end else if (s1_zero) begin
      a_sel = '0;
    end else begin
      a_sel = {band_q[DATA_W-1], band_q};
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      prod <= a_sel * vec_q;
    end
  end

  // accumulate stage, exact in 40 bits
  always_ff @(posedge clk) begin
    if (req_fire && (req.op == OP_COMPUTE)) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // output register, frees the sequencer while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      rsp_row <= row[ROW_W-1:0];
      rsp_sum <= row_err ? '0 : acc;
      rsp_err <= row_err;
    end
  end

endmodule

FILE: hdl/tbmv_checker.sv
`include "triangular_band_matvec_top_assert.svh"

module tbmv_checker import tbmv_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input op_t                      req_op,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic [ROW_W-1:0]         rsp_row_index,
  input logic signed [SUM_W-1:0]  rsp_sum,
  input logic                     rsp_index_error
);

  logic [1:0] pending;
  logic [1:0] pending_next;
  logic       comp_fire;
  logic       rsp_fire;

  assign comp_fire = req_valid && req_ready && (req_op == OP_COMPUTE);
  assign rsp_fire  = rsp_valid && rsp_ready;

  // computes accepted and not yet delivered
  always_comb begin
    pending_next = pending;
    if (comp_fire && !rsp_fire) begin
      pending_next = pending + 2'd1;
    end else if (!comp_fire && rsp_fire) begin
      pending_next = pending - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  `TBMV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
  `TBMV_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_sum) && $stable(rsp_row_index) && $stable(rsp_index_error), "result changed while stalled")
  `TBMV_ASSERT_IMPL(a_err_zero, rsp_valid && rsp_index_error, rsp_sum == '0, "out of range row with nonzero sum")
  `TBMV_ASSERT_IMPL(a_no_orphan, rsp_valid, pending != 2'd0, "result without a compute transaction")
  `TBMV_ASSERT_ALWAYS(a_depth, pending != 2'd3, "more than two computes in flight")

endmodule

bind triangular_band_matvec_top tbmv_checker u_tbmv_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_op          (req.op),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_row_index   (rsp.row_index),
  .rsp_sum         (rsp.sum),
  .rsp_index_error (rsp.index_error)
);

FILE: bench/tbmv_row_checker.sv
`timescale 1ns / 100ps

module tbmv_row_checker import tbmv_pkg::*; #(
  parameter int MAX_SIZE      = 1024,
  parameter int MAX_BAND_ROWS = 32
) (
  input  logic        clk,
  input  logic        rst,
  tbmv_cfg_if         cfg,
  tbmv_req_if         req,
  tbmv_rsp_if         rsp,
  output int unsigned mismatches,
  output int unsigned rows_pending
);

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [SUM_W-1:0] sum;
    logic                    index_error;
  } row_result_t;

  logic signed [DATA_W-1:0] band_mem [MAX_SIZE*MAX_BAND_ROWS];
  logic signed [DATA_W-1:0] vec_mem  [MAX_SIZE];

  logic               upper_q;
  logic               unit_q;
  logic [1:0]         trans_q;
  logic [CDATA_W-1:0] order_q;
  logic [BROW_W-1:0]  k_q;

  row_result_t expected_rows [$];

  // exact band dot product of one row of op(A) with the stored vector
  function automatic row_result_t predict_row_sum(input logic [ROW_W-1:0] row);
    row_result_t r;
    int      n;
    int      i;
    int      k;
    int      j;
    int      col;
    int      brow;
    bit      tr;
    bit      fwd;
    longint  acc;
    longint  xv;
    n = (order_q > MAX_SIZE) ? MAX_SIZE : int'(order_q);
    i = int'(row);
    r.row_index   = row;
    r.sum         = '0;
    r.index_error = 1'b0;
    if (i >= n) begin
      r.index_error = 1'b1;
      return r;
    end
    k   = int'(k_q);
    tr  = (trans_q != 2'd0);
    fwd = upper_q ^ tr;
    acc = 0;
    for (int d = 0; d <= k; d++) begin
      if (fwd) begin
        j = i + d;
        if (j >= n) break;
      end else begin
        if (d > i) break;
        j = i - d;
      end
      col  = tr ? i : j;
      brow = upper_q ? (k - d) : d;
      xv   = vec_mem[j];
      if (d == 0 && unit_q) acc += xv * 32768;
      else if (brow < MAX_BAND_ROWS) acc += longint'(band_mem[brow + col*MAX_BAND_ROWS]) * xv;
    end
    r.sum = acc[SUM_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    row_result_t want;
    if (rst) begin
      upper_q  = 1'b1;
      unit_q   = 1'b0;
      trans_q  = 2'd0;
      order_q  = VECTOR_LENGTH_RESET;
      k_q      = '0;
      expected_rows.delete();
      mismatches   <= 0;
      rows_pending <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_UPPER_BAND:     upper_q = cfg.data[0];
          CFG_UNIT_DIAGONAL:  unit_q  = cfg.data[0];
          CFG_TRANSPOSE_MODE: trans_q = cfg.data[1:0];
          CFG_VECTOR_LENGTH:  order_q = cfg.data;
          CFG_BAND_WIDTH:     k_q     = cfg.data[BROW_W-1:0];
          default: ;
        endcase
      end

      if (rsp.valid && rsp.ready) begin
        if (expected_rows.size() == 0) begin
          $error("result with no pending row: row_index %0d", rsp.row_index);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_rows.pop_front();
          if (rsp.row_index !== want.row_index ||
              rsp.sum !== want.sum ||
              rsp.index_error !== want.index_error)
            mismatches <= mismatches + 1;
          if (rsp.row_index !== want.row_index)
            $error("row_index expected %0d actual %0d", want.row_index, rsp.row_index);
          if (rsp.sum !== want.sum)
            $error("sum expected %0d actual %0d", $signed(want.sum), $signed(rsp.sum));
          if (rsp.index_error !== want.index_error)
            $error("index_error expected %0d actual %0d", want.index_error, rsp.index_error);
        end
      end

      if (req.valid && req.ready) begin
        case (req.op)
          OP_BAND_WRITE: band_mem[req.band_row + req.index*MAX_BAND_ROWS] = req.value;
          OP_VEC_WRITE:  vec_mem[req.index] = req.value;
          OP_COMPUTE:    expected_rows.push_back(predict_row_sum(req.index));
          default: ;
        endcase
      end

      rows_pending <= expected_rows.size();
    end
  end

endmodule

FILE: bench/tb_triangular_band_matvec_top.sv
`timescale 1ns / 100ps

module tb_triangular_band_matvec_top;
  import tbmv_pkg::*;

  localparam int MAX_SIZE      = 1024;
  localparam int MAX_BAND_ROWS = 32;
  localparam int ITEM_TARGET   = 1550;
  localparam int CALM_TAIL     = 200;   // last items run with no idling
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int FIXED_PHASES  = 10;

  // op code the block has no use for; it must swallow it quietly
  localparam op_t      OP_UNUSED  = 2'd3;
  // register index past the last one, writes there are dropped
  localparam cfg_idx_t CFG_UNUSED = 3'd7;

  logic clk;
  logic rst;

  tbmv_cfg_if cfg_bus ();
  tbmv_req_if req_bus ();
  tbmv_rsp_if rsp_bus ();

  int unsigned mismatches;
  int unsigned rows_pending;
  int unsigned cycles = 0;

  // stimulus-side shadow of the configuration, used to know which
  // store entries a compute row is going to read
  int sh_upper = 1;
  int sh_unit  = 0;
  int sh_trans = 0;
  int sh_order = 1024;
  int sh_k     = 0;

  // entries written so far; a compute never touches an unwritten one
  bit band_set [MAX_SIZE*MAX_BAND_ROWS];
  bit vec_set  [MAX_SIZE];

  bit calm     = 1'b0;   // no idling on either side while set
  bit req_held = 1'b0;   // request valid currently driven high
  int items_sent = 0;
  int rsp_stall  = 0;

  triangular_band_matvec_top #(
    .MAX_SIZE      (MAX_SIZE),
    .MAX_BAND_ROWS (MAX_BAND_ROWS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  tbmv_row_checker #(
    .MAX_SIZE      (MAX_SIZE),
    .MAX_BAND_ROWS (MAX_BAND_ROWS)
  ) row_check (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_bus),
    .req          (req_bus),
    .rsp          (rsp_bus),
    .mismatches   (mismatches),
    .rows_pending (rows_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: ready drops in random bursts
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      rsp_stall     <= 0;
    end else if (rsp_stall > 0) begin
      rsp_bus.ready <= 1'b0;
      rsp_stall     <= rsp_stall - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rsp_bus.ready <= 1'b0;
      rsp_stall     <= $urandom_range(1, 5) - 1;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // mostly random data, now and then the two extremes of Q1.15
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // one request transaction; valid stays high into the next call unless
  // an idle burst is drawn right after acceptance
  task automatic send_item(input op_t op, input int idx, input int brow,
                           input logic [DATA_W-1:0] val);
    req_bus.valid    <= 1'b1;
    req_bus.op       <= op;
    req_bus.index    <= ROW_W'(idx);
    req_bus.band_row <= BROW_W'(brow);
    req_bus.value    <= val;
    req_held = 1'b1;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    if (op == OP_BAND_WRITE) band_set[brow + idx*MAX_BAND_ROWS] = 1'b1;
    if (op == OP_VEC_WRITE)  vec_set[idx] = 1'b1;
    if (op != OP_UNUSED) items_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      req_held = 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // sender holds off until every pending row has come back, then lets
  // any trailing write finish inside the block
  task automatic wait_results_drained();
    if (req_held) begin
      req_bus.valid <= 1'b0;
      req_held = 1'b0;
    end
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input int data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CDATA_W'(data);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  // full register set, only ever with the block idle
  task automatic apply_settings(input int upper, input int unit, input int trans,
                                input int order, input int k);
    wait_results_drained();
    write_register(CFG_UPPER_BAND, upper);
    write_register(CFG_UNIT_DIAGONAL, unit);
    write_register(CFG_TRANSPOSE_MODE, trans);
    write_register(CFG_VECTOR_LENGTH, order);
    write_register(CFG_BAND_WIDTH, k);
    cfg_bus.valid <= 1'b0;
    sh_upper = upper;
    sh_unit  = unit;
    sh_trans = trans;
    sh_order = order;
    sh_k     = k;
    @(posedge clk);
  endtask

  // write whatever the row is about to read that holds no data yet
  task automatic fill_row(input int row);
    int n;
    int j;
    int col;
    int brow;
    bit tr;
    bit fwd;
    n   = (sh_order > MAX_SIZE) ? MAX_SIZE : sh_order;
    tr  = (sh_trans != 0);
    fwd = (sh_upper != 0) ^ tr;
    if (row >= n) return;
    for (int d = 0; d <= sh_k; d++) begin
      if (fwd) begin
        j = row + d;
        if (j >= n) break;
      end else begin
        if (d > row) break;
        j = row - d;
      end
      col  = tr ? row : j;
      brow = (sh_upper != 0) ? (sh_k - d) : d;
      if (!vec_set[j])
        send_item(OP_VEC_WRITE, j, $urandom_range(0, 31), pick_value());
      // unit diagonal term never uses a band store entry
      if (!(d == 0 && sh_unit != 0) && !band_set[brow + col*MAX_BAND_ROWS])
        send_item(OP_BAND_WRITE, col, brow, pick_value());
    end
  endtask

  task automatic compute_row(input int row);
    fill_row(row);
    send_item(OP_COMPUTE, row, $urandom_range(0, 31), DATA_W'($urandom));
  endtask

  // random traffic under the current settings; most activity stays in a
  // window of at most 64 rows so band entries get reused
  task automatic run_phase(input int count, input bit hold_midway);
    int n_eff;
    int win_lo;
    int win_span;
    int row;
    int sel;
    n_eff    = (sh_order > MAX_SIZE) ? MAX_SIZE : sh_order;
    win_span = (n_eff > 64) ? 64 : ((n_eff > 0) ? n_eff : 1);
    win_lo   = (n_eff > 64) ? $urandom_range(0, n_eff - 64) : 0;
    for (int i = 0; i < count && items_sent < ITEM_TARGET; i++) begin
      if (items_sent >= ITEM_TARGET - CALM_TAIL) calm = 1'b1;
      if (hold_midway && i == count / 2) wait_results_drained();
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        case ($urandom_range(0, 9))
          0: row = $urandom_range(0, MAX_SIZE - 1);
          1: row = 0;
          2: row = (n_eff > 0) ? n_eff - 1 : MAX_SIZE - 1;
          default: row = win_lo + $urandom_range(0, win_span - 1);
        endcase
        compute_row(row);
      end else if (sel < 72) begin
        row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_SIZE - 1)
                                          : win_lo + $urandom_range(0, win_span - 1);
        send_item(OP_BAND_WRITE, row, $urandom_range(0, 31), pick_value());
      end else if (sel < 94) begin
        row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_SIZE - 1)
                                          : win_lo + $urandom_range(0, win_span - 1);
        send_item(OP_VEC_WRITE, row, $urandom_range(0, 31), pick_value());
      end else if (sel < 98) begin
        send_item(OP_UNUSED, $urandom_range(0, MAX_SIZE - 1), $urandom_range(0, 31),
                  DATA_W'($urandom));
      end else begin
        wait_results_drained();
      end
    end
  endtask

  // upper, unit, transpose, order, band width for the first phases:
  // defaults, widest band, both triangles, all transpose codes, order
  // of one, order zero and an order past the store size
  int fixed_cfg [FIXED_PHASES][5] = '{
    '{1, 0, 0, 1024,  0},
    '{1, 0, 0,   40, 31},
    '{0, 0, 0,   40,  5},
    '{1, 1, 1,   64,  8},
    '{0, 1, 1,   33, 31},
    '{1, 0, 2,   20,  3},
    '{0, 0, 3,    1, 31},
    '{1, 1, 3, 1024, 31},
    '{0, 1, 0,    0,  7},
    '{1, 0, 1, 2047, 12}
  };

  initial begin
    int phase_no;
    int order;
    int k;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= CFG_UPPER_BAND;
    cfg_bus.data     <= '0;
    req_bus.valid    <= 1'b0;
    req_bus.op       <= OP_BAND_WRITE;
    req_bus.index    <= '0;
    req_bus.band_row <= '0;
    req_bus.value    <= '0;
    rst              <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, upper band with k zero over the full order
    send_item(OP_VEC_WRITE, 0, 0, 16'h8000);
    send_item(OP_BAND_WRITE, 0, 0, 16'h8000);
    send_item(OP_COMPUTE, 0, 0, 16'h0000);          // most negative squared
    send_item(OP_VEC_WRITE, 1023, 31, 16'h7fff);
    send_item(OP_BAND_WRITE, 1023, 0, 16'h7fff);
    send_item(OP_COMPUTE, 1023, 31, 16'hffff);      // last row, largest positive operands
    send_item(OP_VEC_WRITE, 1022, 0, 16'h7fff);
    send_item(OP_BAND_WRITE, 1022, 0, 16'h8000);
    send_item(OP_COMPUTE, 1022, 0, 16'h0000);       // mixed signs
    send_item(OP_BAND_WRITE, 1023, 31, 16'hffff);   // top band row, unused at k zero
    send_item(OP_UNUSED, 1023, 31, 16'hffff);       // ignored, no result

    // tiny order with the widest band, unit diagonal, transpose code three
    wait_results_drained();
    write_register(CFG_UNUSED, 11'h7ff);
    cfg_bus.valid <= 1'b0;
    apply_settings(1, 1, 3, 3, 31);
    compute_row(0);
    compute_row(2);
    compute_row(3);                                  // row at the order
    compute_row(1023);                               // row far out of range

    // order zero: every row is out of range
    apply_settings(0, 0, 0, 0, 5);
    compute_row(0);

    // random phases, table first and then drawn settings
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase_no < FIXED_PHASES) begin
        apply_settings(fixed_cfg[phase_no][0], fixed_cfg[phase_no][1],
                       fixed_cfg[phase_no][2], fixed_cfg[phase_no][3],
                       fixed_cfg[phase_no][4]);
      end else begin
        case ($urandom_range(0, 19))
          0:       order = 0;
          1:       order = $urandom_range(1025, 2047);
          2, 3:    order = 1024;
          4, 5:    order = $urandom_range(65, 1024);
          default: order = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 5))
          0:       k = 0;
          1:       k = 31;
          default: k = $urandom_range(0, 31);
        endcase
        apply_settings($urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 3), order, k);
      end
      // some phases run with no idling at all
      if (items_sent < ITEM_TARGET - CALM_TAIL)
        calm = ($urandom_range(0, 3) == 0);
      run_phase(120, phase_no == 1);
      phase_no++;
    end

    calm = 1'b1;
    wait_results_drained();
    if (mismatches == 0 && rows_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
